/* src/evlm_pkg.sv */
`timescale 1ns / 1ps
package evlm_pkg;

  localparam int unsigned MAG_W   = 16;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned NDIG    = MAG_W / DIG_W;
  localparam int unsigned DCNT_W  = $clog2(NDIG);
  localparam int unsigned MC_W    = MAG_W + DIG_W * (NDIG - 1);
  localparam int unsigned PROD_W  = MC_W + DIG_W;

  localparam int unsigned RMS_W   = 16;
  localparam int unsigned SQ_W    = 2 * RMS_W;
  localparam int unsigned SQ_ITER = RMS_W;
  localparam int unsigned SREM_W  = RMS_W + 2;
  localparam int unsigned STRY_W  = RMS_W + 4;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned DUR_W   = 24;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned OUT_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_ON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_OFF = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANG       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_PERIOD = 8'd3;

  localparam logic [LVL_W-1:0] RST_SPEECH_ON  = 16'd393;
  localparam logic [LVL_W-1:0] RST_SPEECH_OFF = 16'd197;
  localparam logic [DUR_W-1:0] RST_HANG       = 24'd9600;
  localparam logic [DUR_W-1:0] RST_LVL_PERIOD = 24'd1600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_DET
  } state_e;

  typedef struct packed {
    logic             speaking;
    logic [RMS_W-1:0] rms;
    logic             report;
    logic             ended;
    logic             started;
  } result_t;

endpackage

/* src/energy_vad_level_meter_top.sv */
`timescale 1ns / 1ps
// Energy voice detector and level meter. Each counted sample (the first MAX_PACKET of a
// packet) adds its square to the packet sum, one 4-bit digit of the magnitude per cycle;
// the next sample can be taken in the last digit step unless this one ends the packet. A
// sample past the packet capacity adds nothing. The sample that ends a packet is followed
// by a restoring divide of the sum by the count (one quotient bit a cycle), an integer
// square root (2 bits a cycle) and a detector step; the result then sits in the
// output register while new samples are taken. A packet end that reaches the detector
// while the previous result has not been taken waits for it.
module energy_vad_level_meter_top #(
  parameter int unsigned MAX_PACKET = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [evlm_pkg::MAG_W-1:0]         s_axis_tdata,   // [15:0] sample
  input  logic                               s_axis_tlast,   // packet_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] speech_started, [1] speech_ended, [2] level_report, [18:3] rms_level,
  // [19] speaking, [23:20] zero
  output logic [evlm_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [evlm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [evlm_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_PACKET + 1);
  localparam int unsigned SW = 30 + CW;
  localparam int unsigned IW = $clog2(SW);

  evlm_pkg::state_e state_q, state_d;
  logic [evlm_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [IW-1:0]               it_q, it_d;

  logic [evlm_pkg::LVL_W-1:0] on_q, off_q;
  logic [evlm_pkg::DUR_W-1:0] hang_q, period_q;

  logic [SW-1:0]                   sum_q, sum_d;
  logic [CW-1:0]                   count_q;
  logic [evlm_pkg::MC_W-1:0]       mcand_q;
  logic [evlm_pkg::MAG_W-1:0]      mplier_q;
  logic                            last_q;
  logic [evlm_pkg::TIME_W-1:0]     clk_cnt_q, voice_t_q, level_t_q;
  logic                            speak_q;

  logic [SW-1:0]  dq_q, dq_nx;
  logic [CW-1:0]  dv_q, rem_q;
  logic [CW:0]    dsh;
  logic           dge;

  logic [evlm_pkg::SQ_W-1:0]    sqv_q;
  logic [evlm_pkg::SREM_W-1:0]  srem_q;
  logic [evlm_pkg::RMS_W-1:0]   root_q;
  logic [evlm_pkg::STRY_W-1:0]  ssh, stry;
  logic                         sge;

  logic                    out_valid_q;
  evlm_pkg::result_t       out_q;

  logic                    accept, counted_in, mul_en, div_go, det_go;
  logic [evlm_pkg::MAG_W-1:0]  mag;
  logic [evlm_pkg::PROD_W-1:0] prod;
  logic [evlm_pkg::TIME_W-1:0] voice_el, level_el;
  logic                        on_hit, off_hit;

  assign cfg_ready_o = 1'b1;

  assign mag        = s_axis_tdata[evlm_pkg::MAG_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
  assign counted_in = count_q < CW'(MAX_PACKET);
  assign prod       = mcand_q * mplier_q[evlm_pkg::DIG_W-1:0];
  assign sum_d      = mul_en ? (sum_q + SW'(prod)) : sum_q;

  assign dsh   = {rem_q, dq_q[SW-1]};
  assign dge   = dsh >= {1'b0, dv_q};
  assign dq_nx = {dq_q[SW-2:0], dge};

  assign ssh  = {srem_q, sqv_q[evlm_pkg::SQ_W-1 -: 2]};
  assign stry = {2'b00, root_q, 2'b01};
  assign sge  = ssh >= stry;

  assign voice_el = clk_cnt_q - voice_t_q;
  assign level_el = clk_cnt_q - level_t_q;
  assign on_hit   = root_q >= on_q;
  assign off_hit  = root_q >= off_q;

  always_comb begin
    state_d       = state_q;
    dcnt_d        = dcnt_q;
    it_d          = it_q;
    s_axis_tready = 1'b0;
    mul_en        = 1'b0;
    div_go        = 1'b0;
    det_go        = 1'b0;
    unique case (state_q)
      evlm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      evlm_pkg::ST_MUL: begin
        mul_en = 1'b1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == evlm_pkg::DCNT_W'(evlm_pkg::NDIG - 1)) begin
          s_axis_tready = !last_q;
          if (last_q) begin
            state_d = evlm_pkg::ST_DIV;
            it_d    = '0;
            div_go  = 1'b1;
          end else begin
            state_d = evlm_pkg::ST_IDLE;
          end
        end
      end
      evlm_pkg::ST_DIV: begin
        it_d = it_q + 1'b1;
        if (it_q == IW'(SW - 1)) begin
          state_d = evlm_pkg::ST_SQRT;
          it_d    = '0;
        end
      end
      evlm_pkg::ST_SQRT: begin
        it_d = it_q + 1'b1;
        if (it_q == IW'(evlm_pkg::SQ_ITER - 1)) begin
          state_d = evlm_pkg::ST_DET;
        end
      end
      evlm_pkg::ST_DET: begin
        if (!out_valid_q || m_axis_tready) begin
          det_go  = 1'b1;
          state_d = evlm_pkg::ST_IDLE;
        end
      end
      default: state_d = evlm_pkg::ST_IDLE;
    endcase
    accept = s_axis_tready && s_axis_tvalid;
    if (accept) begin
      if (counted_in) begin
        state_d = evlm_pkg::ST_MUL;
        dcnt_d  = '0;
      end else if (s_axis_tlast) begin
        state_d = evlm_pkg::ST_DIV;
        it_d    = '0;
        div_go  = 1'b1;
      end else begin
        state_d = evlm_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evlm_pkg::ST_IDLE;
      dcnt_q  <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= evlm_pkg::RST_SPEECH_ON;
      off_q    <= evlm_pkg::RST_SPEECH_OFF;
      hang_q   <= evlm_pkg::RST_HANG;
      period_q <= evlm_pkg::RST_LVL_PERIOD;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        evlm_pkg::REG_SPEECH_ON:  on_q     <= cfg_data_i[evlm_pkg::LVL_W-1:0];
        evlm_pkg::REG_SPEECH_OFF: off_q    <= cfg_data_i[evlm_pkg::LVL_W-1:0];
        evlm_pkg::REG_HANG:       hang_q   <= cfg_data_i;
        evlm_pkg::REG_LVL_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      clk_cnt_q   <= '0;
      voice_t_q   <= '0;
      level_t_q   <= '0;
      speak_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (div_go) begin
        sum_q <= '0;
      end else begin
        sum_q <= sum_d;
      end
      if (accept) begin
        clk_cnt_q <= clk_cnt_q + 1'b1;
        last_q    <= s_axis_tlast;
      end
      if (div_go) begin
        count_q <= '0;
      end else if (accept && counted_in) begin
        count_q <= count_q + 1'b1;
      end
      if (det_go) begin
        out_valid_q <= 1'b1;
        if (!speak_q && on_hit) begin
          speak_q   <= 1'b1;
          voice_t_q <= clk_cnt_q;
        end else if (speak_q) begin
          if (off_hit) begin
            voice_t_q <= clk_cnt_q;
          end else if (voice_el > {8'd0, hang_q}) begin
            speak_q <= 1'b0;
          end
        end
        if (level_el >= {8'd0, period_q}) begin
          level_t_q <= clk_cnt_q;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mcand_q  <= evlm_pkg::MC_W'(mag);
      mplier_q <= mag;
    end else if (mul_en) begin
      mcand_q  <= mcand_q << evlm_pkg::DIG_W;
      mplier_q <= mplier_q >> evlm_pkg::DIG_W;
    end
    if (div_go) begin
      dq_q  <= sum_d;
      dv_q  <= count_q;
      rem_q <= '0;
    end else if (state_q == evlm_pkg::ST_DIV) begin
      dq_q  <= dq_nx;
      rem_q <= CW'(dge ? (dsh - {1'b0, dv_q}) : dsh);
      if (it_q == IW'(SW - 1)) begin
        sqv_q  <= evlm_pkg::SQ_W'(dq_nx);
        srem_q <= '0;
        root_q <= '0;
      end
    end else if (state_q == evlm_pkg::ST_SQRT) begin
      sqv_q  <= sqv_q << 2;
      srem_q <= evlm_pkg::SREM_W'(sge ? (ssh - stry) : ssh);
      root_q <= {root_q[evlm_pkg::RMS_W-2:0], sge};
    end
    if (det_go) begin
      out_q.rms      <= root_q;
      out_q.started  <= !speak_q && on_hit;
      out_q.ended    <= speak_q && !off_hit && (voice_el > {8'd0, hang_q});
      out_q.report   <= level_el >= {8'd0, period_q};
      out_q.speaking <= (!speak_q && on_hit) ||
                        (speak_q && (off_hit || !(voice_el > {8'd0, hang_q})));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(evlm_pkg::OUT_W - $bits(evlm_pkg::result_t)){1'b0}}, out_q};

endmodule

/* src/evlm_chk.sv */
`timescale 1ns / 1ps
module evlm_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [evlm_pkg::OUT_W-1:0] m_axis_tdata
);

  evlm_pkg::result_t res;
  assign res = m_axis_tdata[$bits(evlm_pkg::result_t)-1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_start_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.started && res.ended))
    else $error("speech started and ended in one packet");

  a_state_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!res.started || res.speaking) && (!res.ended || !res.speaking))
    else $error("speaking flag disagrees with transition");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.rms <= 16'd32768) &&
                      (m_axis_tdata[evlm_pkg::OUT_W-1:$bits(evlm_pkg::result_t)] == '0))
    else $error("rms out of range or padding set");

endmodule

bind energy_vad_level_meter_top evlm_chk u_evlm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
